// File: rtl/dss_pkg.sv
// Package with the shared constants and types of the descending score sorter.
package dss_pkg;

  localparam int unsigned DSS_MAX_RECORDS = 64;
  localparam int unsigned DSS_SCORE_BITS  = 16;
  localparam int unsigned DSS_CODE_BITS   = 4;
  localparam int unsigned DSS_PAYLOAD_BITS = 32;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } dss_state_e;

  typedef struct packed {
    logic insert;
    logic shift;
  } dss_cell_ctrl_t;

endpackage

// File: rtl/dss_in_if.sv
// Input channel interface carrying one record word per handshake.
interface dss_in_if #(
  parameter int unsigned ScoreBits = dss_pkg::DSS_SCORE_BITS
);
  logic                                   valid;
  logic                                   ready;
  logic signed [ScoreBits-1:0]            score;
  logic [dss_pkg::DSS_CODE_BITS-1:0]      piece_code;
  logic [dss_pkg::DSS_PAYLOAD_BITS-1:0]   payload;
  logic                                   last_in;

  modport source (output valid, score, piece_code, payload, last_in, input ready);
  modport sink (input valid, score, piece_code, payload, last_in, output ready);
endinterface

// File: rtl/dss_out_if.sv
// Output channel interface carrying one sorted record word per handshake.
interface dss_out_if #(
  parameter int unsigned ScoreBits = dss_pkg::DSS_SCORE_BITS
);
  logic                                   valid;
  logic                                   ready;
  logic signed [ScoreBits-1:0]            sorted_score;
  logic [dss_pkg::DSS_CODE_BITS-1:0]      sorted_piece_code;
  logic [dss_pkg::DSS_PAYLOAD_BITS-1:0]   sorted_payload;
  logic                                   last_out;
  logic                                   overflow;

  modport source (output valid, sorted_score, sorted_piece_code, sorted_payload, last_out,
                  overflow, input ready);
  modport sink (input valid, sorted_score, sorted_piece_code, sorted_payload, last_out,
                overflow, output ready);
endinterface

// File: rtl/dss_cell.sv
// One cell of the insertion chain, holding a single record in sorted position.
module dss_cell #(
  parameter int unsigned ScoreBits = dss_pkg::DSS_SCORE_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dss_pkg::dss_cell_ctrl_t              ctrl_i,
  input  logic signed [ScoreBits-1:0]          new_score_i,
  input  logic [dss_pkg::DSS_CODE_BITS-1:0]    new_code_i,
  input  logic [dss_pkg::DSS_PAYLOAD_BITS-1:0] new_payload_i,
  input  logic                                 prev_valid_i,
  input  logic                                 prev_keep_i,
  input  logic signed [ScoreBits-1:0]          prev_score_i,
  input  logic [dss_pkg::DSS_CODE_BITS-1:0]    prev_code_i,
  input  logic [dss_pkg::DSS_PAYLOAD_BITS-1:0] prev_payload_i,
  input  logic                                 next_valid_i,
  input  logic signed [ScoreBits-1:0]          next_score_i,
  input  logic [dss_pkg::DSS_CODE_BITS-1:0]    next_code_i,
  input  logic [dss_pkg::DSS_PAYLOAD_BITS-1:0] next_payload_i,
  output logic                                 valid_o,
  output logic                                 keep_o,
  output logic signed [ScoreBits-1:0]          score_o,
  output logic [dss_pkg::DSS_CODE_BITS-1:0]    code_o,
  output logic [dss_pkg::DSS_PAYLOAD_BITS-1:0] payload_o
);

  logic                                 valid_q, valid_d;
  logic signed [ScoreBits-1:0]          score_q, score_d;
  logic [dss_pkg::DSS_CODE_BITS-1:0]    code_q, code_d;
  logic [dss_pkg::DSS_PAYLOAD_BITS-1:0] payload_q, payload_d;

  // The held record stays put when the new record does not go strictly before it.
  assign keep_o = valid_q && ((new_score_i < score_q) ||
                              ((new_score_i == score_q) && (new_code_i >= code_q)));

  always_comb begin
    valid_d   = valid_q;
    score_d   = score_q;
    code_d    = code_q;
    payload_d = payload_q;
    if (ctrl_i.insert) begin
      if (!keep_o) begin
        valid_d = valid_q | prev_valid_i;
        if (prev_keep_i) begin
          score_d   = new_score_i;
          code_d    = new_code_i;
          payload_d = new_payload_i;
        end else begin
          score_d   = prev_score_i;
          code_d    = prev_code_i;
          payload_d = prev_payload_i;
        end
      end
    end else if (ctrl_i.shift) begin
      valid_d   = next_valid_i;
      score_d   = next_score_i;
      code_d    = next_code_i;
      payload_d = next_payload_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q   <= score_d;
    code_q    <= code_d;
    payload_q <= payload_d;
  end

  assign valid_o   = valid_q;
  assign score_o   = score_q;
  assign code_o    = code_q;
  assign payload_o = payload_q;

endmodule

// File: rtl/descending_score_sorter_top.sv
// Top level of the descending score sorter built on a chain of insertion cells.
//
//   Channel  Dir  Handshake        Word
//   in_i     in   valid / ready    score, piece_code, payload, last_in
//   out_o    out  valid / ready    sorted_score, sorted_piece_code, sorted_payload,
//                                  last_out, overflow
//
// While loading, one input word is taken every cycle, and the chain registers it in place.
// After the word marked last, input is held off while the chain drains from cell zero,
// one output word per cycle the sink is ready. Reset empties the chain at once and
// clears overflow. A stalled sink simply freezes the chain; nothing is lost.
module descending_score_sorter_top #(
  parameter int unsigned MaxRecords = dss_pkg::DSS_MAX_RECORDS,
  parameter int unsigned ScoreBits  = dss_pkg::DSS_SCORE_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  dss_in_if.sink    in_i,
  dss_out_if.source out_o
);

  dss_pkg::dss_state_e     state_q, state_d;
  logic                    overflow_q, overflow_d;
  dss_pkg::dss_cell_ctrl_t ctrl;
  logic                    in_accept;
  logic                    full;

  logic                                 cell_valid   [MaxRecords];
  logic                                 cell_keep    [MaxRecords];
  logic signed [ScoreBits-1:0]          cell_score   [MaxRecords];
  logic [dss_pkg::DSS_CODE_BITS-1:0]    cell_code    [MaxRecords];
  logic [dss_pkg::DSS_PAYLOAD_BITS-1:0] cell_payload [MaxRecords];
  logic [MaxRecords-1:0]                valid_vec;

  for (genvar g = 0; g < MaxRecords; g++) begin : g_cell
    logic                                 prev_valid, prev_keep, next_valid;
    logic signed [ScoreBits-1:0]          prev_score, next_score;
    logic [dss_pkg::DSS_CODE_BITS-1:0]    prev_code, next_code;
    logic [dss_pkg::DSS_PAYLOAD_BITS-1:0] prev_payload, next_payload;

    if (g == 0) begin : g_head
      assign prev_valid   = 1'b1;
      assign prev_keep    = 1'b1;
      assign prev_score   = in_i.score;
      assign prev_code    = in_i.piece_code;
      assign prev_payload = in_i.payload;
    end else begin : g_body
      assign prev_valid   = cell_valid[g-1];
      assign prev_keep    = cell_keep[g-1];
      assign prev_score   = cell_score[g-1];
      assign prev_code    = cell_code[g-1];
      assign prev_payload = cell_payload[g-1];
    end

    if (g == MaxRecords - 1) begin : g_tail
      assign next_valid   = 1'b0;
      assign next_score   = cell_score[g];
      assign next_code    = cell_code[g];
      assign next_payload = cell_payload[g];
    end else begin : g_link
      assign next_valid   = cell_valid[g+1];
      assign next_score   = cell_score[g+1];
      assign next_code    = cell_code[g+1];
      assign next_payload = cell_payload[g+1];
    end

    dss_cell #(
      .ScoreBits(ScoreBits)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .new_score_i    (in_i.score),
      .new_code_i     (in_i.piece_code),
      .new_payload_i  (in_i.payload),
      .prev_valid_i   (prev_valid),
      .prev_keep_i    (prev_keep),
      .prev_score_i   (prev_score),
      .prev_code_i    (prev_code),
      .prev_payload_i (prev_payload),
      .next_valid_i   (next_valid),
      .next_score_i   (next_score),
      .next_code_i    (next_code),
      .next_payload_i (next_payload),
      .valid_o        (cell_valid[g]),
      .keep_o         (cell_keep[g]),
      .score_o        (cell_score[g]),
      .code_o         (cell_code[g]),
      .payload_o      (cell_payload[g])
    );

    assign valid_vec[g] = cell_valid[g];
  end

  assign full      = cell_valid[MaxRecords-1];
  assign in_i.ready = (state_q == dss_pkg::ST_LOAD);
  assign in_accept = in_i.valid && in_i.ready;

  assign out_o.valid             = (state_q == dss_pkg::ST_DRAIN);
  assign out_o.sorted_score      = cell_score[0];
  assign out_o.sorted_piece_code = cell_code[0];
  assign out_o.sorted_payload    = cell_payload[0];
  assign out_o.last_out          = !cell_valid[1];
  assign out_o.overflow          = overflow_q;

  assign ctrl.insert = in_accept && !full;
  assign ctrl.shift  = out_o.valid && out_o.ready;

  always_comb begin
    state_d    = state_q;
    overflow_d = overflow_q;
    unique case (state_q)
      dss_pkg::ST_LOAD: begin
        if (in_accept) begin
          if (full) begin
            overflow_d = 1'b1;
          end
          if (in_i.last_in) begin
            state_d = dss_pkg::ST_DRAIN;
          end
        end
      end
      dss_pkg::ST_DRAIN: begin
        if (ctrl.shift && !cell_valid[1]) begin
          state_d    = dss_pkg::ST_LOAD;
          overflow_d = 1'b0;
        end
      end
      default: begin
        state_d    = dss_pkg::ST_LOAD;
        overflow_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dss_pkg::ST_LOAD;
      overflow_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      overflow_q <= overflow_d;
    end
  end

  // The chain always holds its records packed toward cell zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("Gap in the cell chain.");

  // A drained word always comes from an occupied head cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> cell_valid[0])
    else $error("Output word offered from an empty head cell.");

  // Loading and draining never overlap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("Input and output open at the same time.");

  // A record arriving at a full chain raises the overflow flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && full) |=> overflow_q)
    else $error("Dropped record did not raise overflow.");

  // A word into a chain with room lands in one more cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.insert |=> ($countones(valid_vec) == $countones($past(valid_vec)) + 1))
    else $error("Insertion did not grow the chain by one.");

endmodule
